// ----- src/poa_pkg.sv -----
// Package for the prescaled oversampling averager: widths, codes, state and control types.
// No dependencies; every other file refers to it by scoped names.
package poa_pkg;

  localparam int MAX_SAMPLES = 16;
  localparam int IDX_W       = $clog2(MAX_SAMPLES);
  localparam int DATA_W      = 32;
  localparam int PRE_W       = 16;
  localparam int OVS_W       = 4;
  localparam int CNT_W       = OVS_W + 1;
  localparam int SUM_W       = DATA_W + OVS_W + 1;
  localparam int MAG_W       = SUM_W - 1;
  localparam int STEP_W      = $clog2(MAG_W + 1);
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = PRE_W;

  typedef enum logic [1:0] {
    OUT_INACTIVE  = 2'd0,
    OUT_PRESCALED = 2'd1,
    OUT_SAMPLED   = 2'd2,
    OUT_MEASURED  = 2'd3
  } outcome_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRE_HI = 2'd0,
    CFG_OVS_HI = 2'd1,
    CFG_PRE_LO = 2'd2,
    CFG_OVS_LO = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SUM,
    ST_ABS,
    ST_DIV,
    ST_NEG,
    ST_OUT
  } seq_state_t;

  typedef enum logic [2:0] {
    ARITH_IDLE,
    ARITH_CLEAR,
    ARITH_ACC,
    ARITH_ABS,
    ARITH_DIV,
    ARITH_NEG
  } arith_op_t;

  typedef struct packed {
    logic [PRE_W-1:0] pre_hi;
    logic [OVS_W-1:0] ovs_hi;
    logic [PRE_W-1:0] pre_lo;
    logic [OVS_W-1:0] ovs_lo;
  } cfg_t;

  typedef struct packed {
    arith_op_t        op;
    logic             load_in;
    logic             hold_sample;
    logic             hold_quot;
    logic [CNT_W-1:0] divisor;
  } arith_ctrl_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } store_ctrl_t;

endpackage

// ----- src/poa_tick_if.sv -----
// Input channel: one tick beat with power flag and sensor sample.
// Depends on poa_pkg.
interface poa_tick_if;
  logic                             valid;
  logic                             ready;
  logic                             external_power;
  logic signed [poa_pkg::DATA_W-1:0] sample_value;

  modport source (output valid, output external_power, output sample_value, input ready);
  modport sink (input valid, input external_power, input sample_value, output ready);
endinterface

// ----- src/poa_result_if.sv -----
// Output channel: one result beat with outcome code and latest value.
// Depends on poa_pkg.
interface poa_result_if;
  logic                              valid;
  logic                              ready;
  poa_pkg::outcome_t                 outcome;
  logic signed [poa_pkg::DATA_W-1:0] latest_value;

  modport source (output valid, output outcome, output latest_value, input ready);
  modport sink (input valid, input outcome, input latest_value, output ready);
endinterface

// ----- src/poa_store.sv -----
// Sample store: one write port, one registered read port, per-entry valid bits.
// Entries never written since reset read as zero. Depends on poa_pkg.
module poa_store (
  input  logic                         clk,
  input  logic                         rst,
  input  poa_pkg::store_ctrl_t         sctrl,
  input  logic [poa_pkg::DATA_W-1:0]   wr_data,
  output logic [poa_pkg::DATA_W-1:0]   rd_data
);

  logic [poa_pkg::DATA_W-1:0]      mem [poa_pkg::MAX_SAMPLES];
  logic [poa_pkg::MAX_SAMPLES-1:0] valid;
  logic [poa_pkg::DATA_W-1:0]      rd_mem;
  logic                            rd_vld;

  always_ff @(posedge clk) begin
    if (sctrl.wr_en) begin
      mem[sctrl.wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (sctrl.wr_en) begin
      valid[sctrl.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sctrl.rd_en) begin
      rd_mem <= mem[sctrl.rd_addr];
      rd_vld <= valid[sctrl.rd_addr];
    end
  end

  assign rd_data = rd_vld ? rd_mem : '0;

endmodule

// ----- src/poa_arith.sv -----
// Shared adder datapath: accumulates stored samples, takes the magnitude,
// divides by restoring steps and restores the sign. Depends on poa_pkg.
module poa_arith (
  input  logic                       clk,
  input  logic                       rst,
  input  poa_pkg::arith_ctrl_t       actrl,
  input  logic [poa_pkg::DATA_W-1:0] sample_in,
  input  logic [poa_pkg::DATA_W-1:0] rd_data,
  output logic [poa_pkg::DATA_W-1:0] sample,
  output logic [poa_pkg::DATA_W-1:0] held
);

  logic [poa_pkg::SUM_W-1:0] acc;
  logic [poa_pkg::MAG_W-1:0] dq;
  logic [poa_pkg::CNT_W-1:0] rem;
  logic                      neg;
  logic [poa_pkg::SUM_W-1:0] add_a;
  logic [poa_pkg::SUM_W-1:0] add_b;
  logic                      add_cin;
  logic [poa_pkg::SUM_W-1:0] add_sum;
  logic                      trial_ok;

  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_cin = 1'b0;
    case (actrl.op)
      poa_pkg::ARITH_ACC: begin
        add_a = acc;
        add_b = {{(poa_pkg::SUM_W - poa_pkg::DATA_W){rd_data[poa_pkg::DATA_W-1]}}, rd_data};
      end
      poa_pkg::ARITH_ABS: begin
        add_b   = ~acc;
        add_cin = 1'b1;
      end
      poa_pkg::ARITH_DIV: begin
        add_a   = poa_pkg::SUM_W'({rem, dq[poa_pkg::MAG_W-1]});
        add_b   = ~poa_pkg::SUM_W'(actrl.divisor);
        add_cin = 1'b1;
      end
      poa_pkg::ARITH_NEG: begin
        add_b   = ~poa_pkg::SUM_W'(dq);
        add_cin = 1'b1;
      end
      default: begin
        add_a = '0;
      end
    endcase
  end

  assign add_sum  = add_a + add_b + poa_pkg::SUM_W'(add_cin);
  assign trial_ok = !add_sum[poa_pkg::SUM_W-1];

  always_ff @(posedge clk) begin
    case (actrl.op)
      poa_pkg::ARITH_CLEAR: begin
        acc <= '0;
      end
      poa_pkg::ARITH_ACC: begin
        acc <= add_sum;
      end
      poa_pkg::ARITH_ABS: begin
        neg <= acc[poa_pkg::SUM_W-1];
        rem <= '0;
        dq  <= acc[poa_pkg::SUM_W-1] ? add_sum[poa_pkg::MAG_W-1:0] : acc[poa_pkg::MAG_W-1:0];
      end
      poa_pkg::ARITH_DIV: begin
        if (trial_ok) begin
          rem <= add_sum[poa_pkg::CNT_W-1:0];
        end else begin
          rem <= {rem[poa_pkg::CNT_W-2:0], dq[poa_pkg::MAG_W-1]};
        end
        dq <= {dq[poa_pkg::MAG_W-2:0], trial_ok};
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (actrl.load_in) begin
      sample <= sample_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (actrl.hold_sample) begin
      held <= sample;
    end else if (actrl.hold_quot) begin
      held <= neg ? add_sum[poa_pkg::DATA_W-1:0] : dq[poa_pkg::DATA_W-1:0];
    end
  end

endmodule

// ----- src/poa_seq.sv -----
// Sequencer: prescale and oversample counters, tick decision and the
// sum/divide schedule for the shared adder and the store. Depends on poa_pkg.
module poa_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  poa_pkg::cfg_t         cfg,
  input  logic                  tick_valid,
  input  logic                  tick_power,
  input  logic                  result_ready,
  output logic                  tick_ready,
  output logic                  result_valid,
  output poa_pkg::outcome_t     outcome,
  output poa_pkg::arith_ctrl_t  actrl,
  output poa_pkg::store_ctrl_t  sctrl
);

  poa_pkg::seq_state_t          state;
  poa_pkg::seq_state_t          state_next;
  logic                         power;
  logic [poa_pkg::PRE_W-1:0]    prescale_count;
  logic [poa_pkg::PRE_W-1:0]    prescale_count_next;
  logic [poa_pkg::OVS_W-1:0]    oversample_count;
  logic [poa_pkg::OVS_W-1:0]    oversample_count_next;
  logic [poa_pkg::OVS_W-1:0]    ovs_sel;
  logic [poa_pkg::STEP_W-1:0]   step;
  poa_pkg::outcome_t            outcome_next;
  logic [poa_pkg::PRE_W-1:0]    pre;
  logic [poa_pkg::OVS_W-1:0]    ovs_raw;
  logic [poa_pkg::OVS_W-1:0]    ovs_eff;
  logic [poa_pkg::PRE_W-1:0]    pc_cl;
  logic [poa_pkg::OVS_W-1:0]    oc_cl;
  logic                         take_sample;
  logic                         tick_fire;
  logic                         result_fire;
  logic [poa_pkg::STEP_W-1:0]   sum_last;

  assign tick_fire   = tick_valid && tick_ready;
  assign result_fire = result_valid && result_ready;
  assign sum_last    = poa_pkg::STEP_W'(ovs_sel) + poa_pkg::STEP_W'(1);

  always_comb begin
    pre     = power ? cfg.pre_hi : cfg.pre_lo;
    ovs_raw = power ? cfg.ovs_hi : cfg.ovs_lo;
    if (32'(ovs_raw) > poa_pkg::MAX_SAMPLES - 1) begin
      ovs_eff = poa_pkg::OVS_W'(poa_pkg::MAX_SAMPLES - 1);
    end else begin
      ovs_eff = ovs_raw;
    end
    pc_cl = (prescale_count > pre) ? pre : prescale_count;
    oc_cl = (oversample_count > ovs_eff) ? ovs_eff : oversample_count;
    prescale_count_next   = prescale_count;
    oversample_count_next = oversample_count;
    take_sample           = 1'b0;
    if (pre == '0) begin
      outcome_next = poa_pkg::OUT_INACTIVE;
    end else if (pc_cl == '0) begin
      take_sample         = 1'b1;
      prescale_count_next = pre;
      if (oc_cl == '0) begin
        outcome_next          = poa_pkg::OUT_MEASURED;
        oversample_count_next = ovs_eff;
      end else begin
        outcome_next          = poa_pkg::OUT_SAMPLED;
        oversample_count_next = oc_cl - poa_pkg::OVS_W'(1);
      end
    end else begin
      outcome_next          = poa_pkg::OUT_PRESCALED;
      prescale_count_next   = pc_cl - poa_pkg::PRE_W'(1);
      oversample_count_next = oc_cl;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      poa_pkg::ST_IDLE:   if (tick_fire) state_next = poa_pkg::ST_DECIDE;
      poa_pkg::ST_DECIDE: begin
        state_next = (outcome_next == poa_pkg::OUT_MEASURED) ? poa_pkg::ST_SUM
                                                             : poa_pkg::ST_OUT;
      end
      poa_pkg::ST_SUM:    if (step == sum_last) state_next = poa_pkg::ST_ABS;
      poa_pkg::ST_ABS:    state_next = poa_pkg::ST_DIV;
      poa_pkg::ST_DIV: begin
        if (step == poa_pkg::STEP_W'(poa_pkg::MAG_W - 1)) state_next = poa_pkg::ST_NEG;
      end
      poa_pkg::ST_NEG:    state_next = poa_pkg::ST_OUT;
      poa_pkg::ST_OUT:    if (result_fire) state_next = poa_pkg::ST_IDLE;
      default:            state_next = poa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    tick_ready          = 1'b0;
    result_valid        = 1'b0;
    actrl.op            = poa_pkg::ARITH_IDLE;
    actrl.load_in       = 1'b0;
    actrl.hold_sample   = 1'b0;
    actrl.hold_quot     = 1'b0;
    actrl.divisor       = poa_pkg::CNT_W'(ovs_sel) + poa_pkg::CNT_W'(1);
    sctrl.wr_en         = 1'b0;
    sctrl.wr_addr       = poa_pkg::IDX_W'(oc_cl);
    sctrl.rd_en         = 1'b0;
    sctrl.rd_addr       = poa_pkg::IDX_W'(step);
    case (state)
      poa_pkg::ST_IDLE: begin
        tick_ready    = 1'b1;
        actrl.load_in = tick_valid;
      end
      poa_pkg::ST_DECIDE: begin
        actrl.op          = poa_pkg::ARITH_CLEAR;
        actrl.hold_sample = take_sample;
        sctrl.wr_en       = take_sample;
      end
      poa_pkg::ST_SUM: begin
        sctrl.rd_en = (step <= poa_pkg::STEP_W'(ovs_sel));
        actrl.op    = (step != '0) ? poa_pkg::ARITH_ACC : poa_pkg::ARITH_IDLE;
      end
      poa_pkg::ST_ABS: actrl.op = poa_pkg::ARITH_ABS;
      poa_pkg::ST_DIV: actrl.op = poa_pkg::ARITH_DIV;
      poa_pkg::ST_NEG: begin
        actrl.op        = poa_pkg::ARITH_NEG;
        actrl.hold_quot = 1'b1;
      end
      poa_pkg::ST_OUT: result_valid = 1'b1;
      default: begin
        tick_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= poa_pkg::ST_IDLE;
      prescale_count   <= '0;
      oversample_count <= '0;
      outcome          <= poa_pkg::OUT_INACTIVE;
      power            <= 1'b0;
      ovs_sel          <= '0;
      step             <= '0;
    end else begin
      state <= state_next;
      if (tick_fire) begin
        power <= tick_power;
      end
      case (state)
        poa_pkg::ST_DECIDE: begin
          prescale_count   <= prescale_count_next;
          oversample_count <= oversample_count_next;
          outcome          <= outcome_next;
          ovs_sel          <= ovs_eff;
          step             <= '0;
        end
        poa_pkg::ST_SUM: step <= step + poa_pkg::STEP_W'(1);
        poa_pkg::ST_ABS: step <= '0;
        poa_pkg::ST_DIV: step <= step + poa_pkg::STEP_W'(1);
        default:         step <= step;
      endcase
    end
  end

  a_tick_to_decide: assert property (@(posedge clk) disable iff (rst)
    tick_fire |=> state == poa_pkg::ST_DECIDE)
    else $error("accepted tick not followed by decision");

  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    state == poa_pkg::ST_SUM |-> step <= sum_last)
    else $error("summation ran past the oversample count");

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    state == poa_pkg::ST_DIV |-> step < poa_pkg::STEP_W'(poa_pkg::MAG_W))
    else $error("division ran past its step count");

  a_measured_reload: assert property (@(posedge clk) disable iff (rst)
    (state == poa_pkg::ST_OUT && outcome == poa_pkg::OUT_MEASURED)
      |-> oversample_count == ovs_sel)
    else $error("oversample counter not reloaded after measurement");

  a_result_release: assert property (@(posedge clk) disable iff (rst)
    result_fire |=> tick_ready && !result_valid)
    else $error("block not ready after result beat");

endmodule

// ----- src/prescaled_oversampling_averager_core.sv -----
// Prescaled oversampling averager. One tick beat yields exactly one result beat.
// Inactive, prescaled and sampled ticks go from the decision state straight to the
// output state, which raises result valid. A measuring tick with oversample setting
// N passes the decision state, reads and adds the stored samples over the store's
// single read port, then takes the magnitude, runs 36 restoring division steps and
// restores the sign, all on one shared 37-bit adder. The tick channel is not ready
// while an item is in work or its result waits. The store needs no clearing pass
// after reset; its entries read as zero until written. Configuration writes take
// effect at once and belong between items.
module prescaled_oversampling_averager_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [poa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [poa_pkg::CFG_DATA_W-1:0]    cfg_data,
  poa_tick_if.sink                          tick,
  poa_result_if.source                      result
);

  poa_pkg::cfg_t                cfg;
  poa_pkg::arith_ctrl_t         actrl;
  poa_pkg::store_ctrl_t         sctrl;
  logic [poa_pkg::DATA_W-1:0]   sample;
  logic [poa_pkg::DATA_W-1:0]   rd_data;
  logic [poa_pkg::DATA_W-1:0]   held;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (poa_pkg::cfg_reg_t'(cfg_index))
        poa_pkg::CFG_PRE_HI: cfg.pre_hi <= cfg_data;
        poa_pkg::CFG_OVS_HI: cfg.ovs_hi <= cfg_data[poa_pkg::OVS_W-1:0];
        poa_pkg::CFG_PRE_LO: cfg.pre_lo <= cfg_data;
        poa_pkg::CFG_OVS_LO: cfg.ovs_lo <= cfg_data[poa_pkg::OVS_W-1:0];
        default:             cfg <= cfg;
      endcase
    end
  end

  poa_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .tick_valid   (tick.valid),
    .tick_power   (tick.external_power),
    .result_ready (result.ready),
    .tick_ready   (tick.ready),
    .result_valid (result.valid),
    .outcome      (result.outcome),
    .actrl        (actrl),
    .sctrl        (sctrl)
  );

  poa_store u_store (
    .clk     (clk),
    .rst     (rst),
    .sctrl   (sctrl),
    .wr_data (sample),
    .rd_data (rd_data)
  );

  poa_arith u_arith (
    .clk       (clk),
    .rst       (rst),
    .actrl     (actrl),
    .sample_in (tick.sample_value),
    .rd_data   (rd_data),
    .sample    (sample),
    .held      (held)
  );

  assign result.latest_value = held;

endmodule
